// File: rtl/tli_pkg.sv
// Shared constants for the tabulated linear interpolator.
`timescale 1ns / 1ps

package tli_pkg;

  // Default table depth and fixed field widths.
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned INDEX_W         = 10;
  localparam int unsigned COUNT_W         = 11;
  localparam int unsigned TDATA_IN_W      = 112;
  localparam int unsigned TDATA_OUT_W     = 32;

  // Divider geometry: 64-bit product over a 32-bit span magnitude.
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned ITER_W = $clog2(PROD_W);

  // The correction term is capped at 2^40.
  localparam logic [40:0] QUOT_CAP = 41'h100_0000_0000;

  // Request kinds carried in tuser.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

// File: rtl/tli_div.sv
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor.
`timescale 1ns / 1ps

module tli_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tli_pkg::PROD_W-1:0]  dividend_i,
  input  logic [tli_pkg::DATA_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [tli_pkg::PROD_W-1:0]  quotient_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [tli_pkg::ITER_W-1:0]  iter_q;
  logic [tli_pkg::DATA_W-1:0]  rem_q, rem_d;
  logic [tli_pkg::DATA_W-1:0]  dsr_q;
  logic [tli_pkg::PROD_W-1:0]  dvd_q;
  logic [tli_pkg::DATA_W:0]    shifted;
  logic [tli_pkg::DATA_W:0]    diff;
  logic                        fits;

  // One quotient bit per cycle; dvd_q turns into the quotient as it shifts.
  always_comb begin
    shifted = {rem_q, dvd_q[tli_pkg::PROD_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    fits    = (shifted >= {1'b0, dsr_q});
    rem_d   = fits ? diff[tli_pkg::DATA_W-1:0] : shifted[tli_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == tli_pkg::ITER_W'(tli_pkg::PROD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      dvd_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[tli_pkg::PROD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// File: rtl/tabulated_linear_interpolator_unit.sv
// Top level: breakpoint table, search sequencer and span interpolation.
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: index, abscissa, ordinate, point
//                                            tuser: mode (0 load, 1 query)
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: interp_value; tuser: inside_range
// cfg       in   cfg_we_i                     cfg_wdata_i: entry_count
//
// A load request leaves the unit ready for the next one. A query holds off the
// input through s search steps (about log2(n+1)), the span reads, a multiply and
// the 64-step restoring divider. Fewer than two entries, a point outside the table
// or on the last abscissa skip the search; a zero-width span skips multiply and divide.
// No clearing pass after reset; only the control state and the entry count are reset.
// A finished result waits in the output register; the next request is
// taken meanwhile, and a second result waits until the first is taken.
`timescale 1ns / 1ps

module tabulated_linear_interpolator_unit #(
  parameter int unsigned TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tli_pkg::COUNT_W-1:0]      cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [9:0] entry_index, [41:10] abscissa_value, [73:42] ordinate_value,
  // [105:74] query_point, [111:106] zero
  input  logic [tli_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
  // [0] mode
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] interp_value
  output logic [tli_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
  // [0] inside_range
  output logic                             m_axis_tuser
);

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CW > tli_pkg::COUNT_W) ? CW : tli_pkg::COUNT_W;
  localparam int unsigned DW    = tli_pkg::DATA_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_X0, ST_XL, ST_SRCH, ST_SPAN1, ST_SPAN2,
    ST_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_FIN, ST_OUT
  } state_e;

  state_e state_q;

  // Request fields
  logic [tli_pkg::INDEX_W-1:0] in_index;
  logic signed [DW-1:0]        in_abs, in_ord, in_point;
  logic                        in_accept;

  assign in_index  = s_axis_tdata[9:0];
  assign in_abs    = s_axis_tdata[41:10];
  assign in_ord    = s_axis_tdata[73:42];
  assign in_point  = s_axis_tdata[105:74];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Entry count register
  logic [tli_pkg::COUNT_W-1:0] entry_count_q;
  logic [CMP_W-1:0]            count_ext;
  logic [CW-1:0]               n_use;
  logic [AW-1:0]               last_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  assign count_ext = CMP_W'(entry_count_q);
  assign n_use     = (count_ext > CMP_W'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_ext);
  assign last_addr = AW'(n_use - 1'b1);

  // Table memory, one word per entry: {ordinate, abscissa}
  logic [2*DW-1:0] mem [TABLE_DEPTH];
  logic [2*DW-1:0] rdata_q;
  logic [AW-1:0]   rd_addr;
  logic [31:0]     slot_ext;
  logic            mem_we;

  assign slot_ext = 32'(in_index);
  assign mem_we   = in_accept && (s_axis_tuser == tli_pkg::MODE_LOAD)
                    && (slot_ext < 32'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[slot_ext[AW-1:0]] <= {in_ord, in_abs};
    end
    rdata_q <= mem[rd_addr];
  end

  logic signed [DW-1:0] rd_x, rd_d;
  assign rd_x = rdata_q[DW-1:0];
  assign rd_d = rdata_q[2*DW-1:DW];

  // Query working registers
  logic signed [DW-1:0] p_q, x1_q, d1_q, d2_q;
  logic [CW-1:0]        lo_q, hi_q;
  logic [AW-1:0]        mid_q, idx_q;
  logic [DW-1:0]        mag_dd_q, mag_dp_q, mag_dx_q;
  logic                 neg_q;
  logic [tli_pkg::PROD_W-1:0] prod_q;
  logic [40:0]          t_q;
  logic signed [DW-1:0] res_q;
  logic                 inside_q;
  logic [DW-1:0]        m_data_q;
  logic                 m_user_q, m_valid_q;
  logic                 out_load;

  // Search step
  logic          le;
  logic [CW-1:0] lo_n, hi_n, mid_ext;
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid_n, idx_n;
  logic          search_go;

  always_comb begin
    le        = (rd_x <= p_q);
    mid_ext   = CW'(mid_q);
    lo_n      = le ? (mid_ext + 1'b1) : lo_q;
    hi_n      = le ? hi_q : mid_ext;
    search_go = (lo_n < hi_n);
    mid_sum   = (CW + 1)'(lo_n) + (CW + 1)'(hi_n);
    mid_n     = mid_sum[AW:1];
    priority if (lo_n == '0) begin
      idx_n = AW'(1);
    end else if (lo_n >= n_use) begin
      idx_n = last_addr;
    end else begin
      idx_n = AW'(lo_n);
    end
  end

  always_comb begin
    unique case (state_q)
      ST_X0:    rd_addr = last_addr;
      ST_XL:    rd_addr = AW'(n_use >> 1);
      ST_SRCH:  rd_addr = search_go ? mid_n : AW'(idx_n - 1'b1);
      ST_SPAN1: rd_addr = idx_q;
      default:  rd_addr = '0;
    endcase
  end

  // Span differences
  logic signed [DW:0] dd, dp, dx, dd_abs, dp_abs, dx_abs;
  always_comb begin
    dd     = (DW + 1)'(rd_d) - (DW + 1)'(d1_q);
    dp     = (DW + 1)'(rd_x) - (DW + 1)'(p_q);
    dx     = (DW + 1)'(rd_x) - (DW + 1)'(x1_q);
    dd_abs = dd[DW] ? -dd : dd;
    dp_abs = dp[DW] ? -dp : dp;
    dx_abs = dx[DW] ? -dx : dx;
  end

  // Divider
  logic                       div_start, div_done;
  logic [tli_pkg::PROD_W-1:0] quot;

  assign div_start = (state_q == ST_DIV_GO);

  tli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (mag_dx_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Final correction and saturation
  logic signed [41:0] fin_sum;
  logic signed [DW-1:0] fin_sat;
  always_comb begin
    fin_sum = neg_q ? (42'(d2_q) + $signed({1'b0, t_q}))
                    : (42'(d2_q) - $signed({1'b0, t_q}));
    priority if (fin_sum > 42'sh0_7FFF_FFFF) begin
      fin_sat = 32'sh7FFF_FFFF;
    end else if (fin_sum < -42'sh0_8000_0000) begin
      fin_sat = 32'sh8000_0000;
    end else begin
      fin_sat = fin_sum[DW-1:0];
    end
  end

  // Result moves into the output register when it is empty or being taken
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept && (s_axis_tuser == tli_pkg::MODE_QUERY)) begin
            state_q <= (n_use < CW'(2)) ? ST_OUT : ST_X0;
          end
        end
        ST_X0: begin
          if (rd_x > p_q) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_XL;
          end
        end
        ST_XL: begin
          if (p_q >= rd_x) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (!search_go) begin
            state_q <= ST_SPAN1;
          end
        end
        ST_SPAN1: state_q <= ST_SPAN2;
        ST_SPAN2: state_q <= (dx == '0) ? ST_OUT : ST_MUL;
        ST_MUL:   state_q <= ST_DIV_GO;
        ST_DIV_GO: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        p_q      <= in_point;
        res_q    <= '0;
        inside_q <= 1'b0;
      end
      ST_XL: begin
        lo_q  <= '0;
        hi_q  <= n_use;
        mid_q <= AW'(n_use >> 1);
        if (p_q == rd_x) begin
          res_q    <= rd_d;
          inside_q <= 1'b1;
        end
      end
      ST_SRCH: begin
        lo_q  <= lo_n;
        hi_q  <= hi_n;
        mid_q <= mid_n;
        idx_q <= idx_n;
      end
      ST_SPAN1: begin
        x1_q <= rd_x;
        d1_q <= rd_d;
      end
      ST_SPAN2: begin
        d2_q     <= rd_d;
        mag_dd_q <= dd_abs[DW-1:0];
        mag_dp_q <= dp_abs[DW-1:0];
        mag_dx_q <= dx_abs[DW-1:0];
        neg_q    <= dd[DW] ^ dp[DW] ^ dx[DW];
        res_q    <= rd_d;
        inside_q <= 1'b1;
      end
      ST_MUL: begin
        prod_q <= mag_dd_q * mag_dp_q;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          t_q <= (quot > tli_pkg::PROD_W'(tli_pkg::QUOT_CAP)) ? tli_pkg::QUOT_CAP
                                                              : quot[40:0];
        end
      end
      ST_FIN: begin
        res_q <= fin_sat;
      end
      ST_OUT: begin
        if (out_load) begin
          m_data_q <= res_q;
          m_user_q <= inside_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
